@@ design/matrix_add_multiply_unit_assert.svh @@
// Assertion macros for the checker file (mam_checker).
`ifndef MATRIX_ADD_MULTIPLY_UNIT_ASSERT_SVH
`define MATRIX_ADD_MULTIPLY_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while in reset.
`define MAM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off while in reset.
`define MAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/mam_pkg.sv @@
package mam_pkg;

    localparam int IDX_W     = 6;
    localparam int IN_DW     = 16;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 3;
    localparam int VAL_W     = 35;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 4;
    localparam int DIM_REG_W = 4;

    localparam logic                 MODE_RST = 1'b1;
    localparam logic [DIM_REG_W-1:0] DIM_RST  = 4'd8;

    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_ROWS_A = 3'd1,
        CFG_COLS_A = 3'd2,
        CFG_ROWS_B = 3'd3,
        CFG_COLS_B = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Controller to datapath command, also carried down the datapath as a tag
    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd;
        logic             clr;
        logic             emit;
        logic             last;
        logic             err;
        logic             add;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_cmd;

endpackage

@@ design/matrix_add_multiply_unit.sv @@
// Write items keep busy low, so they stream one per cycle while the controller is idle.
// A compute item holds busy while it reads the stores: rows*cols reads (add),
// rows_a*cols_b*cols_a (multiply) or none (dimension error); one shared MAC, one read port per store.
// A result's tag goes through r_s1 and r_s2 to o_valid; the next item is taken as busy drops.
// Synchronous active-low reset returns the controller to idle and the registers to
// mode 1 and 8x8 shapes; store contents are not cleared.
module matrix_add_multiply_unit
    import mam_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_op,
    input  logic [IDX_W-1:0]         i_elem_index,
    input  logic signed [IN_DW-1:0]  i_elem_value,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DW-1:0]        i_cfg_data,
    output logic                     o_valid,
    output logic [ROW_W-1:0]         o_out_row,
    output logic [COL_W-1:0]         o_out_col,
    output logic signed [VAL_W-1:0]  o_out_value,
    output logic                     o_last,
    output logic                     o_dim_error
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd          cmd;
    logic [AW-1:0] addr_a, addr_b;

    assign o_cfg_ready = 1'b1;

    mam_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_op         (i_op),
        .i_elem_index (i_elem_index),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_busy       (busy),
        .o_cmd        (cmd),
        .o_addr_a     (addr_a),
        .o_addr_b     (addr_b)
    );

    mam_datapath #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_addr_a     (addr_a),
        .i_addr_b     (addr_b),
        .i_elem_index (i_elem_index),
        .i_elem_value (i_elem_value),
        .o_valid      (o_valid),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_out_value  (o_out_value),
        .o_last       (o_last),
        .o_dim_error  (o_dim_error)
    );

endmodule

@@ design/mam_ram.sv @@
module mam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/mam_ctrl.sv @@
module mam_ctrl
    import mam_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_start,
    input  logic [1:0]                                        i_op,
    input  logic [IDX_W-1:0]                                  i_elem_index,
    input  logic                                              i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]                              i_cfg_index,
    input  logic [CFG_DW-1:0]                                 i_cfg_data,
    output logic                                              o_busy,
    output t_cmd                                              o_cmd,
    output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] o_addr_a,
    output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] o_addr_b
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    // Clamp a dimension register into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_REG_W-1:0] r);
        logic [DIM_W-1:0] d;
        if (r == '0) begin
            d = DIM_W'(1);
        end else if (32'(r) > MAX_DIM) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = DIM_W'(r);
        end
        return d;
    endfunction

    logic                 r_mode;
    logic [DIM_REG_W-1:0] r_rows_a, r_cols_a, r_rows_b, r_cols_b;

    t_state r_state, n_state;

    logic [DIM_W-1:0] r_ra, n_ra, r_ca, n_ca, r_cb, n_cb;
    logic [DIM_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [AW-1:0]    r_abase, n_abase, r_bptr, n_bptr;
    logic             r_add, n_add, r_err, n_err;

    logic [DIM_W-1:0] sat_ra, sat_ca, sat_rb, sat_cb, ncols;
    logic             accept, go, wr_ok;
    logic             inner_done, col_done, row_done, run_done;
    logic [AW-1:0]    addr_a;

    assign accept = i_start && (r_state == ST_IDLE);
    assign go     = accept && (t_op'(i_op) == OP_COMPUTE);
    assign wr_ok  = accept && (32'(i_elem_index) < DEPTH);

    assign sat_ra = sat_dim(r_rows_a);
    assign sat_ca = sat_dim(r_cols_a);
    assign sat_rb = sat_dim(r_rows_b);
    assign sat_cb = sat_dim(r_cols_b);

    assign inner_done = r_add || (r_j == r_ca - DIM_W'(1));
    assign ncols      = r_add ? r_ca : r_cb;
    assign col_done   = (r_k == ncols - DIM_W'(1));
    assign row_done   = (r_i == r_ra - DIM_W'(1));
    assign run_done   = r_err || (inner_done && col_done && row_done);
    assign addr_a     = r_abase + (r_add ? AW'(r_k) : AW'(r_j));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RST;
            r_rows_a <= DIM_RST;
            r_cols_a <= DIM_RST;
            r_rows_b <= DIM_RST;
            r_cols_b <= DIM_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:   r_mode   <= i_cfg_data[0];
                CFG_ROWS_A: r_rows_a <= i_cfg_data;
                CFG_COLS_A: r_cols_a <= i_cfg_data;
                CFG_ROWS_B: r_rows_b <= i_cfg_data;
                CFG_COLS_B: r_cols_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (go) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (run_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd    = '0;
        o_busy   = 1'b0;
        o_addr_a = addr_a;
        o_addr_b = r_add ? addr_a : r_bptr;
        case (r_state)
            ST_IDLE: begin
                o_cmd.wr_a = wr_ok && (t_op'(i_op) == OP_WRITE_A);
                o_cmd.wr_b = wr_ok && (t_op'(i_op) == OP_WRITE_B);
            end
            ST_RUN: begin
                o_busy = 1'b1;
                if (r_err) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    o_cmd.err  = 1'b1;
                end else begin
                    o_cmd.rd   = 1'b1;
                    o_cmd.add  = r_add;
                    o_cmd.clr  = r_add || (r_j == '0);
                    o_cmd.emit = inner_done;
                    o_cmd.last = inner_done && col_done && row_done;
                    o_cmd.row  = ROW_W'(r_i);
                    o_cmd.col  = COL_W'(r_k);
                end
            end
            default: ;
        endcase
    end

    // Loop counters and read address generation
    always_comb begin
        n_ra    = r_ra;
        n_ca    = r_ca;
        n_cb    = r_cb;
        n_add   = r_add;
        n_err   = r_err;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_abase = r_abase;
        n_bptr  = r_bptr;
        if (go) begin
            n_ra    = sat_ra;
            n_ca    = sat_ca;
            n_cb    = sat_cb;
            n_add   = !r_mode;
            n_err   = r_mode ? (sat_ca != sat_rb)
                             : ((sat_ra != sat_rb) || (sat_ca != sat_cb));
            n_i     = '0;
            n_j     = '0;
            n_k     = '0;
            n_abase = '0;
            n_bptr  = '0;
        end else if (r_state == ST_RUN && !r_err) begin
            if (!inner_done) begin
                n_j    = r_j + DIM_W'(1);
                n_bptr = r_bptr + AW'(r_cb);
            end else begin
                n_j = '0;
                if (!col_done) begin
                    n_k    = r_k + DIM_W'(1);
                    n_bptr = AW'(r_k) + AW'(1);
                end else begin
                    n_k     = '0;
                    n_bptr  = '0;
                    n_i     = r_i + DIM_W'(1);
                    n_abase = r_abase + AW'(r_ca);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_add   <= 1'b0;
            r_err   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_abase <= '0;
            r_bptr  <= '0;
        end else begin
            r_state <= n_state;
            r_add   <= n_add;
            r_err   <= n_err;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_abase <= n_abase;
            r_bptr  <= n_bptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra <= n_ra;
        r_ca <= n_ca;
        r_cb <= n_cb;
    end

endmodule

@@ design/mam_datapath.sv @@
module mam_datapath
    import mam_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 16
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  t_cmd                                              i_cmd,
    input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] i_addr_a,
    input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] i_addr_b,
    input  logic [IDX_W-1:0]                                  i_elem_index,
    input  logic signed [IN_DW-1:0]                           i_elem_value,
    output logic                                              o_valid,
    output logic [ROW_W-1:0]                                  o_out_row,
    output logic [COL_W-1:0]                                  o_out_col,
    output logic signed [VAL_W-1:0]                           o_out_value,
    output logic                                              o_last,
    output logic                                              o_dim_error
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [31:0]             wide_value;
    logic [DATA_WIDTH-1:0]          wr_data;
    logic [AW-1:0]                  wr_addr;
    logic signed [DATA_WIDTH-1:0]   rd_a, rd_b;
    logic signed [2*DATA_WIDTH-1:0] prod;
    logic signed [VAL_W-1:0]        sum, n_p, acc_next;

    logic signed [VAL_W-1:0] r_p, r_acc;
    t_cmd                    r_s1, r_s2;
    logic                    r_valid, r_last, r_err;
    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        r_col;
    logic signed [VAL_W-1:0] r_value;

    // Cut or sign-extend the written element to the store width
    assign wide_value = 32'(i_elem_value);
    assign wr_data    = wide_value[DATA_WIDTH-1:0];
    assign wr_addr    = AW'(i_elem_index);

    mam_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_a),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (i_addr_a),
        .o_rd_data (rd_a)
    );

    mam_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_b),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (i_addr_b),
        .o_rd_data (rd_b)
    );

    // Stage 1: product or element sum
    assign prod = rd_a * rd_b;
    assign sum  = VAL_W'(rd_a) + VAL_W'(rd_b);
    assign n_p  = r_s1.add ? sum : VAL_W'(prod);

    // Stage 2: accumulate, wrapping at the result width
    assign acc_next = (r_s2.clr ? VAL_W'(0) : r_acc) + r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1    <= '0;
            r_s2    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_s1    <= i_cmd;
            r_s2    <= r_s1;
            r_valid <= r_s2.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        if (r_s2.rd) begin
            r_acc <= acc_next;
        end
        if (r_s2.emit) begin
            r_row   <= r_s2.row;
            r_col   <= r_s2.col;
            r_last  <= r_s2.last;
            r_err   <= r_s2.err;
            r_value <= r_s2.err ? VAL_W'(0) : acc_next;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_row   = r_row;
    assign o_out_col   = r_col;
    assign o_out_value = r_value;
    assign o_last      = r_last;
    assign o_dim_error = r_err;

endmodule

@@ design/mam_checker.sv @@
`include "matrix_add_multiply_unit_assert.svh"

module mam_checker
    import mam_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic [1:0]              i_op,
    input logic                    o_valid,
    input logic [ROW_W-1:0]        o_out_row,
    input logic [COL_W-1:0]        o_out_col,
    input logic signed [VAL_W-1:0] o_out_value,
    input logic                    o_last,
    input logic                    o_dim_error
);

    // A mismatch is a single, final result
    `MAM_ASSERT_IMPL(a_err_is_last, o_valid && o_dim_error, o_last, "error result not last")

    `MAM_ASSERT_IMPL(a_err_zero, o_valid && o_dim_error, (o_out_row == '0) && (o_out_col == '0) && (o_out_value == '0), "error result fields not zero")

    // Busy only follows a compute transfer
    `MAM_ASSERT_IMPL(a_busy_cause, $rose(busy), $past(start) && ($past(i_op) == OP_COMPUTE), "busy without compute")

    // o_valid stays low right after a last result, also for back-to-back computes
    `MAM_ASSERT_NEXT(a_last_gap, o_valid && o_last, !o_valid, "strobe right after last")

endmodule

bind matrix_add_multiply_unit mam_checker u_mam_checker (.*);
